[rtl/matrix_pin_pair_scanner_core_defines.svh]
// ----------------------------------------------------------------------------
// Pin pair scanner: shared assertion macros
// Concurrent assertion wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef MATRIX_PIN_PAIR_SCANNER_CORE_DEFINES_SVH
`define MATRIX_PIN_PAIR_SCANNER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define MPPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define MPPS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

[rtl/mpps_pkg.sv]
// ----------------------------------------------------------------------------
// Pin pair scanner package
// Shared constants and lane/merge result types.
// ----------------------------------------------------------------------------
package mpps_pkg;

    localparam int DEF_PINS   = 16;
    localparam int LEVEL_W    = 16;  // sampled pin levels per transaction
    localparam int LANE_IDX_W = 4;   // index of a lane within the level word
    localparam int OUT_PIN_W  = 4;   // pin index width on the result channel
    localparam int M_DATA_W   = 16;

    typedef struct packed {
        logic hit;       // pin high and not the driven one
        logic conflict;  // hit on a pin other than the recorded first
    } lane_flags_t;

    typedef struct packed {
        logic                  any_hit;
        logic                  multi_hit;
        logic                  any_conflict;
        logic [LANE_IDX_W-1:0] first_lane;
    } merge_res_t;

endpackage

[rtl/mpps_lane.sv]
// ----------------------------------------------------------------------------
// Pin pair scanner lane
// Checks one sensed pin against the driven pin and the recorded pair.
// ----------------------------------------------------------------------------
module mpps_lane
    import mpps_pkg::*;
#(
    parameter int PIN_W = 4,
    parameter int LANE  = 0
) (
    input  logic             level,
    input  logic [PIN_W-1:0] drive_pin,
    input  logic [PIN_W-1:0] pair_first,
    output lane_flags_t      flags
);

    localparam logic [PIN_W-1:0] LANE_PIN = PIN_W'(LANE);

    always_comb begin
        flags.hit      = level && (drive_pin != LANE_PIN);
        flags.conflict = level && (drive_pin != LANE_PIN) && (pair_first != LANE_PIN);
    end

endmodule

[rtl/mpps_merge.sv]
// ----------------------------------------------------------------------------
// Pin pair scanner merge
// Combines lane flags: lowest hit, more than one hit, any conflicting hit.
// ----------------------------------------------------------------------------
module mpps_merge
    import mpps_pkg::*;
#(
    parameter int LANES = 16
) (
    input  lane_flags_t flags [LANES],
    output merge_res_t  res
);

    logic seen;

    always_comb begin
        res  = '0;
        seen = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            res.multi_hit    = res.multi_hit | (seen & flags[i].hit);
            seen             = seen | flags[i].hit;
            res.any_conflict = res.any_conflict | flags[i].conflict;
        end
        res.any_hit = seen;
        // priority: lowest lane wins
        for (int i = LANES - 1; i >= 0; i--) begin
            if (flags[i].hit) begin
                res.first_lane = LANE_IDX_W'(i);
            end
        end
    end

endmodule

[rtl/matrix_pin_pair_scanner_core.sv]
// ----------------------------------------------------------------------------
// Pin pair scanner core
// The result on the m_ side is registered from each accepted input transaction.
// Throughput: 1 transaction per cycle while the output is empty or m_tready is high; all pins
// are checked in parallel lanes and the pair state updates in the same cycle.
// Reset: aresetn low clears the driven pin to 0, the pair state and m_tvalid.
// ----------------------------------------------------------------------------
`include "matrix_pin_pair_scanner_core_defines.svh"

module matrix_pin_pair_scanner_core
    import mpps_pkg::*;
#(
    parameter int PINS = DEF_PINS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [LEVEL_W-1:0]  s_tdata,   // [15:0] pin_levels
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [3:0] next_drive_pin, [4] pair_found,
                                           // [8:5] first_pin, [12:9] second_pin,
                                           // [13] multiple_pairs, [15:14] zero
    output logic                m_tlast    // scan_done
);

    localparam int PIN_W = $clog2(PINS);
    localparam int LANES = (PINS < LEVEL_W) ? PINS : LEVEL_W;
    localparam logic [PIN_W-1:0] LAST_PIN = PIN_W'(PINS - 1);

    logic [PIN_W-1:0] drive_reg, drive_next;
    logic             have_reg, have_next;
    logic [PIN_W-1:0] first_reg, first_next;
    logic [PIN_W-1:0] second_reg, second_next;
    logic             many_reg, many_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_PIN_W-1:0] out_drive_reg, out_first_reg, out_second_reg;
    logic                 out_done_reg, out_found_reg, out_many_reg;

    lane_flags_t lane_flags [LANES];
    merge_res_t  merged;

    logic                      s_accept;
    logic                      done;
    logic                      pair_idle;
    logic                      upd_have, upd_many;
    logic [PIN_W-1:0]          upd_first, upd_second;
    logic [PIN_W+LANE_IDX_W-1:0] lane_ext;
    logic [PIN_W+OUT_PIN_W-1:0]  next_ext, first_ext, second_ext;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mpps_lane #(
            .PIN_W (PIN_W),
            .LANE  (g)
        ) u_lane (
            .level      (s_tdata[g]),
            .drive_pin  (drive_reg),
            .pair_first (first_reg),
            .flags      (lane_flags[g])
        );
    end

    mpps_merge #(
        .LANES (LANES)
    ) u_merge (
        .flags (lane_flags),
        .res   (merged)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign done     = (drive_reg == LAST_PIN);
    assign lane_ext = {{PIN_W{1'b0}}, merged.first_lane};

    // pair update for this sample
    always_comb begin
        upd_have   = have_reg;
        upd_first  = first_reg;
        upd_second = second_reg;
        upd_many   = many_reg;
        if (!have_reg) begin
            if (merged.any_hit) begin
                upd_have   = 1'b1;
                upd_first  = drive_reg;
                upd_second = lane_ext[PIN_W-1:0];
            end
            // any further hit in the same sample is a second pair
            upd_many = many_reg | merged.multi_hit;
        end else begin
            upd_many = many_reg | (merged.any_conflict && (second_reg != drive_reg));
        end
    end

    always_comb begin
        drive_next  = drive_reg;
        have_next   = have_reg;
        first_next  = first_reg;
        second_next = second_reg;
        many_next   = many_reg;
        if (s_accept) begin
            drive_next = done ? '0 : drive_reg + PIN_W'(1);
            if (done) begin
                have_next   = 1'b0;
                first_next  = '0;
                second_next = '0;
                many_next   = 1'b0;
            end else begin
                have_next   = upd_have;
                first_next  = upd_first;
                second_next = upd_second;
                many_next   = upd_many;
            end
        end
    end

    assign next_ext   = {{OUT_PIN_W{1'b0}}, (done ? {PIN_W{1'b0}} : drive_reg + PIN_W'(1))};
    assign first_ext  = {{OUT_PIN_W{1'b0}}, upd_first};
    assign second_ext = {{OUT_PIN_W{1'b0}}, upd_second};

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg     <= '0;
            have_reg      <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            many_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            drive_reg     <= drive_next;
            have_reg      <= have_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            many_reg      <= many_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with each accepted transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_drive_reg  <= next_ext[OUT_PIN_W-1:0];
            out_done_reg   <= done;
            out_found_reg  <= done && upd_have;
            out_first_reg  <= (done && upd_have) ? first_ext[OUT_PIN_W-1:0] : '0;
            out_second_reg <= (done && upd_have) ? second_ext[OUT_PIN_W-1:0] : '0;
            out_many_reg   <= done && upd_have && upd_many;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {2'b00, out_many_reg, out_second_reg, out_first_reg,
                       out_found_reg, out_drive_reg};

    assign pair_idle = !have_reg && !many_reg && (drive_reg == '0);

    `MPPS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")
    `MPPS_ASSERT(a_drive_in_range, drive_reg <= LAST_PIN, "driven pin out of range")
    `MPPS_ASSERT(a_many_needs_pair, many_reg |-> have_reg, "multiple flag without a pair")
    `MPPS_ASSERT(a_scan_end_clears, s_accept && done |=> pair_idle, "scan end left pair state")
    `MPPS_ASSERT(a_done_wraps, m_tvalid && m_tlast |-> out_drive_reg == '0, "no wrap at scan end")

endmodule
